// ----- rtl/lrr_pkg.sv -----
package lrr_pkg;

  localparam int SEED_W = 31;
  localparam int SPAN_W = SEED_W + 1;
  localparam int PROD_W = 46;
  localparam int CNT_W  = 5;

  localparam logic [SEED_W-1:0] LCG_MOD   = 31'h7FFF_FFFF;
  localparam logic [14:0]       LCG_A     = 15'd16807;
  localparam logic [SEED_W-1:0] SEED_RST  = 31'd1;
  localparam logic [CNT_W-1:0]  LAST_STEP = 5'(SEED_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_RED,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic fold;
    logic reduce;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

// ----- rtl/lehmer_random_range.sv -----
// Minimal-standard Lehmer generator (multiplier 16807, modulus 2^31-1) with
// range reduction. Each accepted request advances the seed once and returns
// the new seed modulo (high - low + 1) plus the lower bound, with the bounds
// ordered automatically, together with the raw seed. One request is in work
// at a time: the 31x15 multiply is loaded at the accept edge, then the mod
// 2^31-1 fold and the reduce are registered in turn, the bit-serial
// shift-subtract divider forms the remainder from the 31 seed bits, and the
// output register is loaded once it is free. The next request is taken in
// the cycle after the result is loaded, and not before. A finished result
// waits in the output register, and the next
// request is taken while it waits; its own result then holds until the
// earlier one is taken. Writing cfg_wdata with cfg_we loads the running seed
// directly; the seed resets to 1. Writes belong only in gaps with no request
// in work.
module lehmer_random_range
  import lrr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic        [SEED_W-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [SEED_W-1:0] bound_a,
  input  logic signed [SEED_W-1:0] bound_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SEED_W-1:0] value,
  output logic        [SEED_W-1:0] raw_seed
);

  cmd_t    cmd;
  status_t status;

  lrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lrr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .bound_a   (bound_a),
    .bound_b   (bound_b),
    .value     (value),
    .raw_seed  (raw_seed)
  );

  // one request in work at a time
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in work");

  // a delivered seed is never zero
  a_seed_nonzero : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (raw_seed != '0))
    else $error("zero seed on output");

  a_reset_clears : assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("control state not cleared by reset");

endmodule

// ----- rtl/lrr_ctrl.sv -----
module lrr_ctrl
  import lrr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = S_RED;
      end
      S_RED: begin
        cmd.reduce = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lrr_dp.sv -----
module lrr_dp
  import lrr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic                     cfg_we,
  input  logic        [SEED_W-1:0] cfg_wdata,
  input  logic signed [SEED_W-1:0] bound_a,
  input  logic signed [SEED_W-1:0] bound_b,
  output logic signed [SEED_W-1:0] value,
  output logic        [SEED_W-1:0] raw_seed
);

  logic        [SEED_W-1:0] seed;
  logic        [PROD_W-1:0] prod;
  logic        [SPAN_W-1:0] fold_sum;
  logic signed [SEED_W-1:0] low;
  logic        [SPAN_W-1:0] span;
  logic        [SPAN_W-1:0] rem;
  logic        [CNT_W-1:0]  cnt;

  logic signed [SEED_W-1:0] low_next;
  logic signed [SEED_W-1:0] high_next;
  logic        [SPAN_W-1:0] span_next;
  logic        [SPAN_W-1:0] red_sub;
  logic        [SEED_W-1:0] seed_red;
  logic        [SPAN_W-1:0] rem_shift;
  logic        [SPAN_W:0]   trial;

  // order the bounds and form the inclusive span
  always_comb begin
    if (bound_a > bound_b) begin
      low_next  = bound_b;
      high_next = bound_a;
    end else begin
      low_next  = bound_a;
      high_next = bound_b;
    end
    span_next = SPAN_W'(SPAN_W'(high_next) - SPAN_W'(low_next) + SPAN_W'(1));
  end

  // mod 2^31-1 reduction of the folded product, zero maps to the modulus
  always_comb begin
    red_sub = fold_sum - {1'b0, LCG_MOD};
    if (fold_sum > {1'b0, LCG_MOD}) begin
      seed_red = red_sub[SEED_W-1:0];
    end else begin
      seed_red = fold_sum[SEED_W-1:0];
    end
    if (seed_red == '0) begin
      seed_red = LCG_MOD;
    end
  end

  // restoring division step, one dividend bit per cycle
  always_comb begin
    rem_shift = {rem[SPAN_W-2:0], seed[LAST_STEP - cnt]};
    trial     = {1'b0, rem_shift} - {1'b0, span};
  end

  assign status.div_last = (cnt == LAST_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RST;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end else if (cmd.reduce) begin
      seed <= seed_red;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      prod <= PROD_W'(seed) * PROD_W'(LCG_A);
      low  <= low_next;
      span <= span_next;
    end
    if (cmd.fold) begin
      fold_sum <= {1'b0, prod[SEED_W-1:0]} + SPAN_W'(prod[PROD_W-1:SEED_W]);
    end
    if (cmd.reduce) begin
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[SPAN_W]) begin
        rem <= trial[SPAN_W-1:0];
      end else begin
        rem <= rem_shift;
      end
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.load_out) begin
      value    <= SEED_W'(low + $signed(rem[SEED_W-1:0]));
      raw_seed <= seed;
    end
  end

endmodule
